FILE: hdl/bmf3_pkg.sv
// bmf3_pkg: shared types and constants for the 3x3 box mean filter
// no dependencies; imported by box_mean_filter_3x3_unit
package bmf3_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_WIDTH_W  = 10;
  localparam int unsigned CFG_HEIGHT_W = 13;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam int unsigned WIDTH_RESET  = 512;
  localparam int unsigned HEIGHT_RESET = 512;
  localparam int unsigned HEIGHT_LIMIT = 4096;

  // row counters run up to the height limit plus two
  localparam int unsigned ROW_W = 13;

  // divisor of the neighbourhood mean
  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_4,
    DIV_6,
    DIV_9
  } div_e;

  // rows and cols are the in-frame neighbour counts, 1..3 each
  function automatic div_e div_select(input logic [1:0] rows, input logic [1:0] cols);
    div_e sel;
    case ({rows, cols})
      4'b0101: sel = DIV_1;
      4'b0110, 4'b1001: sel = DIV_2;
      4'b0111, 4'b1101: sel = DIV_3;
      4'b1010: sel = DIV_4;
      4'b1011, 4'b1110: sel = DIV_6;
      4'b1111: sel = DIV_9;
      default: sel = DIV_1;
    endcase
    return sel;
  endfunction

endpackage

FILE: hdl/box_mean_filter_3x3_unit.sv
// box_mean_filter_3x3_unit: streaming 3x3 box mean with edge-aware divisor
// depends on bmf3_pkg; holds two line buffer memories, window and output pipeline

// Takes one pixel per clock in raster order, while the output is not
// stalled, and returns, for each frame position, the truncated mean of the
// in-frame 3x3 neighbours (divisor 9 inside, 6 on edges, 4 at corners). A
// result belongs to the position frame_width+1 pixels before the current
// input, so after the last pixel of a frame send frame_width+1 items with
// tuser (flush) set to drain the remaining results; m_axis_tlast marks the
// frame's final position. A flush inside the frame is taken and ignored.
// Throughput is one item per clock unless m_axis_tready holds the output:
// the line buffers have a write port and a separate read port, and the
// read for the next column is issued while the current pixel is accepted,
// so they never hold up the input. A result passes the middle stage and
// then the output register, two register stages in all. The line buffers
// need no clearing pass after reset. Writing frame_width or frame_height
// restarts the frame; write them only while the block is idle.
module box_mean_filter_3x3_unit
  import bmf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]                 cfg_data_i,
  // pixel input
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]       s_axis_tdata,  // pixel_in
  input  logic                                  s_axis_tuser,  // flush
  // result output
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]       m_axis_tdata,  // pixel_out
  output logic                                  m_axis_tlast   // frame_last
);

  localparam int unsigned TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned WMAX_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WV_W    = (CFG_WIDTH_W > WMAX_W) ? CFG_WIDTH_W : WMAX_W;
  localparam int unsigned W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int unsigned SUM_W   = PIXEL_BITS + 4;
  // reciprocal scale: exact truncation for sums below 2**(PIXEL_BITS+4)
  localparam int unsigned RK      = PIXEL_BITS + 7;
  localparam int unsigned RECIP_W = RK + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned RECIP_1 = 1 << RK;
  localparam int unsigned RECIP_2 = 1 << (RK - 1);
  localparam int unsigned RECIP_3 = ((1 << RK) + 2) / 3;
  localparam int unsigned RECIP_4 = 1 << (RK - 2);
  localparam int unsigned RECIP_6 = ((1 << RK) + 5) / 6;
  localparam int unsigned RECIP_9 = ((1 << RK) + 8) / 9;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    div_e             div;
    logic             last;
  } mid_t;

  // frame geometry, stored already clamped
  logic [WV_W-1:0]   width_q;
  logic [ROW_W-1:0]  height_q;

  // position counters
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;

  // line buffers and prefetched reads
  logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] older_rd_q, newer_rd_q;
  logic                  byp_q;
  logic [PIXEL_BITS-1:0] byp_older_q, byp_newer_q;
  logic [COL_W-1:0]      rd_addr;

  // window: columns one and two back, rows top to bottom
  logic [PIXEL_BITS-1:0] win_q [3][2];

  logic                  mid_valid_q;
  mid_t                  mid_q, mid_d;
  logic                  out_valid_q;
  logic [PIXEL_BITS-1:0] out_pix_q;
  logic                  out_last_q;

  logic                  s_fire, step, ignored, past_end, emit, last, mid_adv;
  logic [PIXEL_BITS-1:0] px_eff, a_eff, b_eff;
  logic [PIXEL_BITS-1:0] nb [3][3];
  logic [2:0]            row_ok, col_ok;
  logic [1:0]            row_cnt, col_cnt;
  logic [WV_W-1:0]       in_col_inc, out_col_inc;
  logic [ROW_W-1:0]      in_row_inc, out_row_inc;
  logic [RECIP_W-1:0]    recip;
  logic [PROD_W-1:0]     prod;

  // handshakes
  assign mid_adv       = mid_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !mid_valid_q || mid_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign past_end = (in_row_q >= height_q);
  assign ignored  = s_axis_tuser && !past_end;
  assign step     = s_fire && !ignored;
  assign px_eff   = past_end ? '0 : s_axis_tdata[PIXEL_BITS-1:0];

  assign a_eff = byp_q ? byp_older_q : older_rd_q;
  assign b_eff = byp_q ? byp_newer_q : newer_rd_q;

  assign emit = ((in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0)))
                && (out_row_q < height_q);

  assign in_col_inc  = WV_W'(in_col_q) + WV_W'(1);
  assign out_col_inc = WV_W'(out_col_q) + WV_W'(1);
  assign in_row_inc  = in_row_q + ROW_W'(1);
  assign out_row_inc = out_row_q + ROW_W'(1);

  assign row_ok  = {(out_row_inc < height_q), 1'b1, (out_row_q != '0)};
  assign col_ok  = {(out_col_inc < width_q), 1'b1, (out_col_q != '0)};
  assign row_cnt = 2'd1 + {1'b0, row_ok[0]} + {1'b0, row_ok[2]};
  assign col_cnt = 2'd1 + {1'b0, col_ok[0]} + {1'b0, col_ok[2]};
  assign last    = (out_row_inc == height_q) && (out_col_inc == width_q);

  // neighbourhood: two stored columns and the incoming one; at column zero
  // the incoming column lies outside the pending position and is masked
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[r][0] = win_q[r][0];
      nb[r][1] = win_q[r][1];
    end
    nb[0][2] = a_eff;
    nb[1][2] = b_eff;
    nb[2][2] = px_eff;
  end

  always_comb begin
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          acc = acc + SUM_W'(nb[r][c]);
        end
      end
    end
    mid_d.sum  = acc;
    mid_d.div  = div_select(row_cnt, col_cnt);
    mid_d.last = last;
  end

  // counters
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (step) begin
      if (in_col_inc >= width_q) begin
        in_col_d = '0;
        in_row_d = in_row_inc;
      end else begin
        in_col_d = in_col_inc[COL_W-1:0];
      end
      if (in_row_d > height_q + ROW_W'(2)) begin
        in_row_d = height_q + ROW_W'(2);
      end
      if (emit) begin
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_inc >= width_q) begin
          out_col_d = '0;
          out_row_d = out_row_inc;
        end else begin
          out_col_d = out_col_inc[COL_W-1:0];
        end
      end
    end
  end

  assign rd_addr = in_col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WV_W'(W_RESET);
      height_q  <= ROW_W'(HEIGHT_RESET);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CFG_FRAME_WIDTH: begin
            if (cfg_data_i[CFG_WIDTH_W-1:0] == '0) begin
              width_q <= WV_W'(1);
            end else if (WV_W'(cfg_data_i[CFG_WIDTH_W-1:0]) > WV_W'(MAX_WIDTH)) begin
              width_q <= WV_W'(MAX_WIDTH);
            end else begin
              width_q <= WV_W'(cfg_data_i[CFG_WIDTH_W-1:0]);
            end
          end
          CFG_FRAME_HEIGHT: begin
            if (cfg_data_i[CFG_HEIGHT_W-1:0] == '0) begin
              height_q <= ROW_W'(1);
            end else if (cfg_data_i[CFG_HEIGHT_W-1:0] > CFG_HEIGHT_W'(HEIGHT_LIMIT)) begin
              height_q <= ROW_W'(HEIGHT_LIMIT);
            end else begin
              height_q <= ROW_W'(cfg_data_i[CFG_HEIGHT_W-1:0]);
            end
          end
          default: begin
          end
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // line buffers: write the current column, prefetch the next one
  always_ff @(posedge clk_i) begin
    if (step) begin
      older_mem[in_col_q] <= b_eff;
      newer_mem[in_col_q] <= px_eff;
    end
    older_rd_q <= older_mem[rd_addr];
    newer_rd_q <= newer_mem[rd_addr];
  end

  // forward a write that hits the prefetched column (one-column frames)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= step && (rd_addr == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_older_q <= b_eff;
    byp_newer_q <= px_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else if (step) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= nb[r][2];
      end
    end
  end

  // middle stage: masked sum and divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (step && emit) begin
      mid_valid_q <= 1'b1;
    end else if (mid_adv) begin
      mid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      mid_q <= mid_d;
    end
  end

  // divide by multiplying with the scaled reciprocal
  always_comb begin
    case (mid_q.div)
      DIV_1:   recip = RECIP_W'(RECIP_1);
      DIV_2:   recip = RECIP_W'(RECIP_2);
      DIV_3:   recip = RECIP_W'(RECIP_3);
      DIV_4:   recip = RECIP_W'(RECIP_4);
      DIV_6:   recip = RECIP_W'(RECIP_6);
      DIV_9:   recip = RECIP_W'(RECIP_9);
      default: recip = RECIP_W'(RECIP_1);
    endcase
  end

  assign prod = PROD_W'(mid_q.sum) * PROD_W'(recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mid_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_adv) begin
      out_pix_q  <= prod[RK +: PIXEL_BITS];
      out_last_q <= mid_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_pix_q);
  assign m_axis_tlast  = out_last_q;

  // checks
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!mid_valid_q && !out_valid_q) |-> s_axis_tready)
    else $error("input stalled with an empty pipeline");

  a_in_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= height_q + ROW_W'(2))
    else $error("input row counter beyond frame end");

  a_out_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q < height_q)
    else $error("output row counter beyond frame");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WV_W'(in_col_q) < width_q) && (WV_W'(out_col_q) < width_q))
    else $error("column counter beyond frame width");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_valid_q && !mid_adv) |=> (mid_valid_q && $stable(mid_q)))
    else $error("stalled middle stage lost its transaction");

endmodule
